>>> rtl/core/sem_pkg.sv
// Shared types and constants for the Sobel edge magnitude block.
package sem_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int CFG_W_BITS    = 11;
    localparam int CFG_H_BITS    = 12;
    localparam int IN_ROW_BITS   = 13;
    localparam int OUT_ROW_BITS  = 12;
    localparam int QUEUE_DEPTH   = 4;
    localparam int PADDR_BITS    = 3;

    localparam logic [CFG_W_BITS-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [CFG_H_BITS-1:0] HEIGHT_RESET = 12'd480;

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_FLUSH = 1'b1
    } opcode_t;

    typedef enum logic {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } reg_index_t;

    typedef enum logic {
        F_IDLE = 1'b0,
        F_READ = 1'b1
    } front_state_t;

    typedef struct packed {
        logic [2:0][2:0][7:0] win;
        logic                 top_ok;
        logic                 bot_ok;
        logic                 left_ok;
        logic                 right_ok;
        logic                 last;
    } job_t;

endpackage

>>> rtl/core/sem_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> rtl/core/sem_front.sv
// Front end: raster counters, row stores, 3x3 window and job generation.
module sem_front #(
    parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,
    input  logic                            s_tuser,
    input  logic [sem_pkg::CFG_W_BITS-1:0]  cfg_width,
    input  logic [sem_pkg::CFG_H_BITS-1:0]  cfg_height,
    input  logic                            q_full,
    output logic                            q_push,
    output sem_pkg::job_t                   q_job
);
    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int RW = sem_pkg::IN_ROW_BITS;
    localparam int OW = sem_pkg::OUT_ROW_BITS;

    sem_pkg::front_state_t state_reg, state_next;
    logic [AW-1:0]        col_reg, col_next;
    logic [RW-1:0]        row_reg, row_next;
    logic [AW-1:0]        ocol_reg, ocol_next;
    logic [OW-1:0]        orow_reg, orow_next;
    logic [7:0]           pix_reg;
    logic [2:0][2:0][7:0] win_reg, win_next;

    logic [WW-1:0] eff_w;
    logic [OW-1:0] eff_h;
    logic [AW-1:0] col_eff;
    logic          accept, draining, ignore, primed, wrap, ram_we;
    logic [7:0]    rd_upper, rd_middle;
    logic          top_ok, bot_ok, left_ok, right_ok, last;

    always_comb begin
        if (cfg_width == '0) begin
            eff_w = WW'(1);
        end else if (32'(cfg_width) > 32'(MAX_WIDTH)) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(cfg_width);
        end
        eff_h   = (cfg_height == '0) ? OW'(1) : cfg_height;
        col_eff = (32'(col_reg) >= 32'(MAX_WIDTH)) ? '0 : col_reg;
    end

    assign accept   = s_tvalid && s_tready;
    assign draining = row_reg >= RW'(eff_h);
    assign ignore   = !draining && (s_tuser == sem_pkg::OP_FLUSH);

    sem_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_ram_upper (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (col_eff),
        .wdata (rd_middle),
        .raddr (col_eff),
        .rdata (rd_upper)
    );

    sem_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_ram_middle (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (col_eff),
        .wdata (pix_reg),
        .raddr (col_eff),
        .rdata (rd_middle)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            sem_pkg::F_IDLE: begin
                if (accept && !ignore) begin
                    state_next = sem_pkg::F_READ;
                end
            end
            sem_pkg::F_READ: state_next = sem_pkg::F_IDLE;
            default:         state_next = sem_pkg::F_IDLE;
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        ram_we   = 1'b0;
        case (state_reg)
            sem_pkg::F_IDLE: s_tready = !q_full;
            sem_pkg::F_READ: ram_we   = 1'b1;
            default:         s_tready = 1'b0;
        endcase
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            win_next[k][0] = win_reg[k][1];
            win_next[k][1] = win_reg[k][2];
        end
        win_next[0][2] = rd_upper;
        win_next[1][2] = rd_middle;
        win_next[2][2] = pix_reg;

        primed   = (row_reg >= RW'(2)) || ((row_reg == RW'(1)) && (col_eff != '0));
        wrap     = (WW'(col_eff) + WW'(1)) >= eff_w;
        top_ok   = orow_reg != '0;
        bot_ok   = (RW'(orow_reg) + RW'(1)) < RW'(eff_h);
        left_ok  = ocol_reg != '0;
        right_ok = (WW'(ocol_reg) + WW'(1)) < eff_w;
        last     = !bot_ok && !right_ok;

        col_next  = wrap ? '0 : AW'(WW'(col_eff) + WW'(1));
        row_next  = wrap ? row_reg + RW'(1) : row_reg;
        ocol_next = ocol_reg;
        orow_next = orow_reg;
        if (primed) begin
            if (last) begin
                col_next  = '0;
                row_next  = '0;
                ocol_next = '0;
                orow_next = '0;
            end else if (!right_ok) begin
                ocol_next = '0;
                orow_next = orow_reg + OW'(1);
            end else begin
                ocol_next = ocol_reg + AW'(1);
            end
        end

        q_push         = ram_we && primed;
        q_job.win      = win_next;
        q_job.top_ok   = top_ok;
        q_job.bot_ok   = bot_ok;
        q_job.left_ok  = left_ok;
        q_job.right_ok = right_ok;
        q_job.last     = last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sem_pkg::F_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
            ocol_reg  <= '0;
            orow_reg  <= '0;
            win_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (ram_we) begin
                col_reg  <= col_next;
                row_reg  <= row_next;
                ocol_reg <= ocol_next;
                orow_reg <= orow_next;
                win_reg  <= win_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pix_reg <= draining ? 8'd0 : s_tdata;
        end
    end
endmodule

>>> rtl/core/sem_queue.sv
// Short job queue between the front end and the arithmetic back end.
module sem_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  sem_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output sem_pkg::job_t pop_job,
    output logic          empty
);
    localparam int DEPTH = sem_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);

    sem_pkg::job_t entry_reg [DEPTH];
    logic [PW-1:0] wptr_reg, rptr_reg;
    logic [PW:0]   count_reg;

    assign full    = count_reg == (PW+1)'(DEPTH);
    assign empty   = count_reg == '0;
    assign pop_job = entry_reg[rptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (push) begin
                wptr_reg <= wptr_reg + PW'(1);
            end
            if (pop) begin
                rptr_reg <= rptr_reg + PW'(1);
            end
            count_reg <= count_reg + (PW+1)'(push) - (PW+1)'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wptr_reg] <= push_job;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full && !pop)) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty) else $error("queue underflow");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (PW+1)'(DEPTH)) else $error("queue count out of range");
endmodule

>>> rtl/core/sem_back.sv
// Back end: weighted sums, border normalization, magnitude and output register.
module sem_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          q_empty,
    input  sem_pkg::job_t q_job,
    output logic          q_pop,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [7:0]    m_tdata,
    output logic          m_tlast
);
    logic               s1_valid_reg;
    logic signed [11:0] sa_reg, sb_reg;
    logic [2:0]         da_reg, db_reg;
    logic               s1_last_reg;
    logic               out_free, s1_free, s1_move;

    logic signed [11:0] sa, sb;
    logic [2:0]         da, db, csum, rsum;
    logic signed [9:0]  cd [3];
    logic signed [9:0]  rd [3];
    logic [2:0]         cmask, rmask;

    logic [9:0]  mag_a, mag_b, q_a, q_b;
    logic [20:0] prod_a, prod_b;
    logic [10:0] qsum;
    logic [9:0]  half;

    assign out_free = !m_tvalid || m_tready;
    assign s1_move  = s1_valid_reg && out_free;
    assign s1_free  = !s1_valid_reg || out_free;
    assign q_pop    = !q_empty && s1_free;

    always_comb begin
        cmask = {q_job.right_ok, 1'b1, q_job.left_ok};
        rmask = {q_job.bot_ok, 1'b1, q_job.top_ok};
        sa = '0;
        sb = '0;
        for (int k = 0; k < 3; k++) begin
            cd[k] = (q_job.bot_ok ? 10'(q_job.win[2][k]) : 10'sd0)
                  - (q_job.top_ok ? 10'(q_job.win[0][k]) : 10'sd0);
            rd[k] = (q_job.right_ok ? 10'(q_job.win[k][2]) : 10'sd0)
                  - (q_job.left_ok ? 10'(q_job.win[k][0]) : 10'sd0);
            if (cmask[k]) begin
                sa = sa + ((k == 1) ? (12'(cd[k]) <<< 1) : 12'(cd[k]));
            end
            if (rmask[k]) begin
                sb = sb + ((k == 1) ? (12'(rd[k]) <<< 1) : 12'(rd[k]));
            end
        end
        csum = 3'd2 + 3'(q_job.left_ok) + 3'(q_job.right_ok);
        rsum = 3'd2 + 3'(q_job.top_ok) + 3'(q_job.bot_ok);
        da   = (q_job.bot_ok ^ q_job.top_ok) ? csum : 3'd0;
        db   = (q_job.right_ok ^ q_job.left_ok) ? rsum : 3'd0;
    end

    always_comb begin
        mag_a  = 10'((sa_reg < 0) ? -sa_reg : sa_reg);
        mag_b  = 10'((sb_reg < 0) ? -sb_reg : sb_reg);
        prod_a = 21'(mag_a) * 21'd683;
        prod_b = 21'(mag_b) * 21'd683;
        case (da_reg)
            3'd2:    q_a = mag_a >> 1;
            3'd3:    q_a = prod_a[20:11];
            3'd4:    q_a = mag_a >> 2;
            default: q_a = mag_a;
        endcase
        case (db_reg)
            3'd2:    q_b = mag_b >> 1;
            3'd3:    q_b = prod_b[20:11];
            3'd4:    q_b = mag_b >> 2;
            default: q_b = mag_b;
        endcase
        qsum = 11'(q_a) + 11'(q_b);
        half = qsum[10:1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_tvalid     <= 1'b0;
        end else begin
            if (s1_free) begin
                s1_valid_reg <= q_pop;
            end
            if (out_free) begin
                m_tvalid <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            sa_reg      <= sa;
            sb_reg      <= sb;
            da_reg      <= da;
            db_reg      <= db;
            s1_last_reg <= q_job.last;
        end
        if (s1_move) begin
            m_tdata <= (half > 10'd255) ? 8'd255 : half[7:0];
            m_tlast <= s1_last_reg;
        end
    end

    a_stage_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && m_tvalid && !m_tready) |=> s1_valid_reg && $stable(sa_reg))
        else $error("stage one lost while output stalled");
    a_pop_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> (!s1_valid_reg || !m_tvalid || m_tready))
        else $error("job popped without room");
    a_out_follows_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s1_valid_reg))
        else $error("result without a job");
endmodule

>>> rtl/core/sobel_edge_magnitude_3x3.sv
// Top level of the 3x3 Sobel edge magnitude block.
//
// Pixels arrive in raster order on the s_ stream: tdata carries the grey
// level and tuser the opcode, where a set tuser marks a flush request without
// a pixel. Edge magnitudes leave on the m_ stream, and tlast marks the final
// pixel of a frame. Results lag the input by one row plus one pixel, so after
// the last pixel of a frame the user sends image_width + 1 flush requests to
// drain the frame. Flush requests sent while pixels are still due are dropped.
// Each request that is not dropped is read from the row store and then
// written back, and s_tready stays low until the write-back. A result then
// passes through a four-entry job queue, one arithmetic stage and the output
// register. When the receiver stalls, the output register holds and the
// queue fills, after which s_tready stays low. Reset clears the counters,
// the window and all valid state and loads a 640 by 480 frame size. The APB
// port writes image_width at address 0 and image_height at address 4; the
// user must write them only while the block is idle, which it does not enforce.
module sobel_edge_magnitude_3x3 #(
    parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // pixel_in
    input  logic                            s_tuser,   // opcode
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [7:0]                      m_tdata,   // edge_value
    output logic                            m_tlast,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sem_pkg::PADDR_BITS-1:0]  paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    logic [sem_pkg::CFG_W_BITS-1:0] width_reg;
    logic [sem_pkg::CFG_H_BITS-1:0] height_reg;
    logic                           cfg_write;
    sem_pkg::reg_index_t            reg_index;

    logic          q_full, q_push, q_pop, q_empty;
    sem_pkg::job_t push_job, pop_job;

    assign pready    = 1'b1;
    assign reg_index = sem_pkg::reg_index_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        case (reg_index)
            sem_pkg::REG_WIDTH:  prdata = 32'(width_reg);
            sem_pkg::REG_HEIGHT: prdata = 32'(height_reg);
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= sem_pkg::WIDTH_RESET;
            height_reg <= sem_pkg::HEIGHT_RESET;
        end else if (cfg_write) begin
            case (reg_index)
                sem_pkg::REG_WIDTH:  width_reg  <= pwdata[sem_pkg::CFG_W_BITS-1:0];
                sem_pkg::REG_HEIGHT: height_reg <= pwdata[sem_pkg::CFG_H_BITS-1:0];
                default:             width_reg  <= width_reg;
            endcase
        end
    end

    sem_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .cfg_width  (width_reg),
        .cfg_height (height_reg),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_job      (push_job)
    );

    sem_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .pop_job  (pop_job),
        .empty    (q_empty)
    );

    sem_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_job    (pop_job),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );
endmodule
